/* hdl/vau_pkg.sv */
// ----------------------------------------------------------------------------
// vau_pkg
// Format codes, lane descriptor types and conversion helpers of the vertex
// attribute unpacker.
// ----------------------------------------------------------------------------
package vau_pkg;

   localparam int FmtW   = 6;
   localparam int InW    = 128;
   localparam int CompW  = 64;
   localparam int OutW   = 4 * CompW;
   localparam int FracW  = 80;
   localparam int IntW   = 32;
   localparam int WordW  = IntW + FracW;
   localparam int PosW   = 7;
   localparam int Lanes  = 4;

   localparam logic [FmtW-1:0] FMT_1F32     = 6'd0;
   localparam logic [FmtW-1:0] FMT_1S32     = 6'd1;
   localparam logic [FmtW-1:0] FMT_1S16     = 6'd2;
   localparam logic [FmtW-1:0] FMT_4F32     = 6'd12;
   localparam logic [FmtW-1:0] FMT_4S32     = 6'd13;
   localparam logic [FmtW-1:0] FMT_4S8      = 6'd15;
   localparam logic [FmtW-1:0] FMT_4U8      = 6'd16;
   localparam logic [FmtW-1:0] FMT_4U8N     = 6'd17;
   localparam logic [FmtW-1:0] FMT_4U8R     = 6'd18;
   localparam logic [FmtW-1:0] FMT_4U8NR    = 6'd19;
   localparam logic [FmtW-1:0] FMT_3U10     = 6'd20;
   localparam logic [FmtW-1:0] FMT_3S10N    = 6'd21;
   localparam logic [FmtW-1:0] FMT_2F16     = 6'd22;
   localparam logic [FmtW-1:0] FMT_4F16     = 6'd23;
   localparam logic [FmtW-1:0] FMT_RGB565   = 6'd24;
   localparam logic [FmtW-1:0] FMT_RGBA4    = 6'd25;
   localparam logic [FmtW-1:0] FMT_3S11N    = 6'd26;
   localparam logic [FmtW-1:0] FMT_2S16S    = 6'd27;
   localparam logic [FmtW-1:0] FMT_3S16S    = 6'd28;
   localparam logic [FmtW-1:0] FMT_RGB8     = 6'd29;
   localparam logic [FmtW-1:0] FMT_RGBX8    = 6'd30;
   localparam logic [FmtW-1:0] FMT_RGBA6    = 6'd31;
   localparam logic [FmtW-1:0] FMT_RGBA8    = 6'd32;
   localparam logic [FmtW-1:0] FMT_2U16     = 6'd33;
   localparam logic [FmtW-1:0] FMT_4U16     = 6'd34;
   localparam logic [FmtW-1:0] FMT_2U16N    = 6'd35;
   localparam logic [FmtW-1:0] FMT_4U16N    = 6'd36;
   localparam logic [FmtW-1:0] FMT_UNKNOWN  = 6'd37;

   // element kinds of the basic formats 0..15 (low two code bits)
   localparam logic [1:0] ELEM_F32 = 2'd0;
   localparam logic [1:0] ELEM_S32 = 2'd1;
   localparam logic [1:0] ELEM_S16 = 2'd2;
   localparam logic [1:0] ELEM_S8  = 2'd3;

   // decoded component: either a small float to widen or a fixed-point magnitude
   typedef struct packed {
      logic              is_float;
      logic              is_half;
      logic [31:0]       fbits;
      logic              sign;
      logic [WordW-1:0]  word;   // int[111:80] . frac[79:0]
      logic              inf;    // repeating fraction continues past the word
      logic              single; // round to fp32 precision
   } desc_type;

   typedef struct packed {
      logic              is_float;
      logic [CompW-1:0]  fres;
      logic              sign;
      logic [WordW-1:0]  word;
      logic              inf;
      logic              single;
      logic              zero;
      logic [PosW-1:0]   pos;
   } lead_type;

   function automatic desc_type zero_desc();
      desc_type d;
      d = '0;
      return d;
   endfunction

   function automatic desc_type one_desc();
      desc_type d;
      d = '0;
      d.word = {32'd1, {FracW{1'b0}}};
      return d;
   endfunction

   function automatic desc_type float_desc(logic [31:0] bits, logic half);
      desc_type d;
      d = '0;
      d.is_float = 1'b1;
      d.is_half  = half;
      d.fbits    = bits;
      return d;
   endfunction

   // signed 32-bit two's complement integer
   function automatic desc_type int_desc(logic [31:0] v);
      desc_type d;
      d = '0;
      d.sign = v[31];
      d.word = {(v[31] ? (32'd0 - v) : v), {FracW{1'b0}}};
      return d;
   endfunction

   function automatic desc_type uint_desc(logic [31:0] v);
      desc_type d;
      d = '0;
      d.word = {v, {FracW{1'b0}}};
      return d;
   endfunction

   // v / (2^k - 1): the quotient is v repeated in binary after the point
   function automatic desc_type unorm_desc(logic [15:0] v, logic [4:0] k, logic [2:0] q);
      desc_type          d;
      logic [FracW-1:0]  frac;
      logic [15:0]       mask;
      logic [83:0]       t84;
      logic [80:0]       t81;
      d    = '0;
      t84  = {14{v[5:0]}};
      t81  = {9{v[8:0]}};
      case (k)
         5'd4:    begin frac = {20{v[3:0]}}; mask = 16'h000F; end
         5'd5:    begin frac = {16{v[4:0]}}; mask = 16'h001F; end
         5'd6:    begin frac = t84[83:4];    mask = 16'h003F; end
         5'd8:    begin frac = {10{v[7:0]}}; mask = 16'h00FF; end
         5'd9:    begin frac = t81[80:1];    mask = 16'h01FF; end
         5'd10:   begin frac = {8{v[9:0]}};  mask = 16'h03FF; end
         default: begin frac = {5{v}};       mask = 16'hFFFF; end
      endcase
      if ((v & mask) == mask) begin
         d.word = {29'd0, q + 3'd1, {FracW{1'b0}}};
      end else begin
         d.word = {29'd0, q, frac};
         d.inf  = ((v & mask) != 16'd0);
      end
      return d;
   endfunction

   // signed 10/11-bit normalized, fp32 rounding
   function automatic desc_type snorm_desc(logic [10:0] v, logic eleven);
      desc_type    d;
      logic [10:0] mag;
      if (v[10]) begin
         mag    = 11'd0 - v;
         d      = '0;
         d.sign = 1'b1;
         if (eleven) d.word = {31'd0, mag, 70'd0};      // |v| / 1024
         else        d.word = {31'd0, mag[9:0], 71'd0}; // |v| / 512
      end else if (eleven) begin
         d = unorm_desc({6'd0, v[9:0]}, 5'd10, 3'd0);
      end else begin
         d = unorm_desc({7'd0, v[8:0]}, 5'd9, 3'd0);
      end
      d.single = 1'b1;
      return d;
   endfunction

   function automatic logic [CompW-1:0] widen32(logic [31:0] b);
      logic [22:0] m;
      logic [4:0]  p;
      logic [22:0] fr;
      logic [10:0] ex;
      m  = b[22:0];
      p  = '0;
      for (int i = 0; i < 23; i++) if (m[i]) p = 5'(i);
      fr = m << (5'd23 - p);
      ex = 11'd874 + {6'd0, p};
      if (b[30:23] == 8'hFF) begin
         if (m == '0) return {b[31], 11'h7FF, 52'd0};
         return {b[31], 11'h7FF, 1'b1, m[21:0], 29'd0};
      end
      if (b[30:23] == 8'h00) begin
         if (m == '0) return {b[31], 63'd0};
         return {b[31], ex, fr, 29'd0};
      end
      return {b[31], 3'd0, b[30:23] + 8'd0, m, 29'd0} + {1'b0, 11'd896, 52'd0};
   endfunction

   function automatic logic [CompW-1:0] widen16(logic [15:0] b);
      logic [9:0]  m;
      logic [3:0]  p;
      logic [9:0]  fr;
      logic [10:0] ex;
      m  = b[9:0];
      p  = '0;
      for (int i = 0; i < 10; i++) if (m[i]) p = 4'(i);
      fr = m << (4'd10 - p);
      ex = 11'd999 + {7'd0, p};
      if (b[14:10] == 5'h1F) begin
         if (m == '0) return {b[15], 11'h7FF, 52'd0};
         return {b[15], 11'h7FF, 1'b1, m[8:0], 42'd0};
      end
      if (b[14:10] == 5'h00) begin
         if (m == '0) return {b[15], 63'd0};
         return {b[15], ex, fr, 42'd0};
      end
      return {b[15], 6'd0, b[14:10], m, 42'd0} + {1'b0, 11'd1008, 52'd0};
   endfunction

endpackage

/* hdl/vertex_attribute_unpack.sv */
// ----------------------------------------------------------------------------
// vertex_attribute_unpack
// Converts one raw vertex attribute of up to 16 bytes into four doubles.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req_     in   tdata = data_lo, data_hi
//  rsp_     out  tdata = comp_x, comp_y, comp_z, comp_w
//  csr_     in   csr_data = attr_format
//
//  One beat per cycle unless rsp stalls. A beat passes through decode,
//  leading-one search, normalizing shift, then rounding into the output register.
//  Reset clears the stage valids and sets the format to unknown.
//  A stalled rsp freezes every stage; req_tready drops only then.
module vertex_attribute_unpack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [vau_pkg::InW-1:0]   req_tdata,   // data_lo, data_hi
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [vau_pkg::OutW-1:0]  rsp_tdata,   // comp_x, comp_y, comp_z, comp_w
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [vau_pkg::FmtW-1:0]  csr_data     // attr_format
);
   import vau_pkg::*;

   logic [FmtW-1:0] fmt_ff;
   logic            en;
   logic            v1_ff, v2_ff, v3_ff, vo_ff;
   desc_type        s1_in [Lanes];
   desc_type        s1_ff [Lanes];
   lead_type        s2_in [Lanes];
   lead_type        s2_ff [Lanes];
   lead_type        s3_in [Lanes];
   lead_type        s3_ff [Lanes];
   logic [OutW-1:0] out_in;
   logic [OutW-1:0] out_ff;

   assign en         = !vo_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_UNKNOWN;
      end else if (csr_valid) begin
         fmt_ff <= csr_data;
      end
   end

   // stage 1: pick the bits of each component
   always_comb begin
      logic [7:0]  b;
      logic [7:0]  br;
      logic [15:0] h;
      logic [31:0] w;
      logic [31:0] p;
      logic [2:0]  q;
      logic [7:0]  r;
      p = req_tdata[31:0];
      q = '0;
      r = '0;
      for (int i = 0; i < Lanes; i++) begin
         b  = req_tdata[8*i +: 8];
         br = req_tdata[8*(3-i) +: 8];
         h  = req_tdata[16*i +: 16];
         w  = req_tdata[32*i +: 32];
         s1_in[i] = (i == 3) ? one_desc() : zero_desc();
         if (fmt_ff <= FMT_4S8) begin
            if (i <= int'(fmt_ff[5:2])) begin
               case (fmt_ff[1:0])
                  ELEM_F32: s1_in[i] = float_desc(w, 1'b0);
                  ELEM_S32: s1_in[i] = int_desc(w);
                  ELEM_S16: s1_in[i] = int_desc({{16{h[15]}}, h});
                  default:  s1_in[i] = int_desc({{24{b[7]}}, b});
               endcase
            end
         end else begin
            unique case (fmt_ff) inside
               FMT_4U8:  s1_in[i] = uint_desc({24'd0, b});
               FMT_4U8N, FMT_RGBA8: s1_in[i] = unorm_desc({8'd0, b}, 5'd8, 3'd0);
               FMT_4U8R:  s1_in[i] = uint_desc({24'd0, br});
               FMT_4U8NR: s1_in[i] = unorm_desc({8'd0, br}, 5'd8, 3'd0);
               FMT_3U10:
                  if (i < 3) s1_in[i] = unorm_desc({6'd0, p[10*i +: 10]}, 5'd10, 3'd0);
               FMT_3S10N:
                  if (i < 3) s1_in[i] = snorm_desc({p[10*i+9], p[10*i +: 10]}, 1'b0);
               FMT_2F16:
                  if (i < 2) s1_in[i] = float_desc({16'd0, h}, 1'b1);
               FMT_4F16: s1_in[i] = float_desc({16'd0, h}, 1'b1);
               FMT_RGB565:
                  if (i == 0)      s1_in[i] = unorm_desc({11'd0, p[15:11]}, 5'd5, 3'd0);
                  else if (i == 1) s1_in[i] = unorm_desc({10'd0, p[10:5]}, 5'd6, 3'd0);
                  else if (i == 2) s1_in[i] = unorm_desc({11'd0, p[4:0]}, 5'd5, 3'd0);
               FMT_RGBA4:
                  s1_in[i] = unorm_desc({12'd0, p[12-4*i +: 4]}, 5'd4, 3'd0);
               FMT_3S11N:
                  if (i == 0)      s1_in[i] = snorm_desc(p[10:0], 1'b1);
                  else if (i == 1) s1_in[i] = snorm_desc(p[21:11], 1'b1);
                  else if (i == 2) s1_in[i] = snorm_desc({p[31], p[31:22]}, 1'b0);
               FMT_2S16S:
                  if (i < 2) s1_in[i] = int_desc({{16{h[15]}}, h});
               FMT_3S16S:
                  if (i < 3) s1_in[i] = int_desc({{16{h[15]}}, h});
               FMT_RGB8, FMT_RGBX8:
                  if (i < 3) s1_in[i] = uint_desc({24'd0, b});
               FMT_RGBA6:
                  if (i < 3) begin
                     // byte / 63 = q + r/63, q <= 4
                     if (b >= 8'd252)      q = 3'd4;
                     else if (b >= 8'd189) q = 3'd3;
                     else if (b >= 8'd126) q = 3'd2;
                     else if (b >= 8'd63)  q = 3'd1;
                     else                  q = 3'd0;
                     r = b - 8'(q * 6'd63);
                     s1_in[i] = unorm_desc({8'd0, r}, 5'd6, q);
                  end
               FMT_2U16:
                  if (i < 2) s1_in[i] = uint_desc({16'd0, h});
               FMT_4U16: s1_in[i] = uint_desc({16'd0, h});
               FMT_2U16N:
                  if (i < 2) s1_in[i] = unorm_desc(h, 5'd16, 3'd0);
               FMT_4U16N: s1_in[i] = unorm_desc(h, 5'd16, 3'd0);
               default: ;
            endcase
         end
      end
   end

   // stage 2: leading-one search and float widening
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         s2_in[i].is_float = s1_ff[i].is_float;
         s2_in[i].fres     = s1_ff[i].is_half ? widen16(s1_ff[i].fbits[15:0])
                                              : widen32(s1_ff[i].fbits);
         s2_in[i].sign     = s1_ff[i].sign;
         s2_in[i].word     = s1_ff[i].word;
         s2_in[i].inf      = s1_ff[i].inf;
         s2_in[i].single   = s1_ff[i].single;
         s2_in[i].zero     = (s1_ff[i].word == '0);
         s2_in[i].pos      = '0;
         for (int j = 0; j < WordW; j++)
            if (s1_ff[i].word[j]) s2_in[i].pos = PosW'(j);
      end
   end

   // stage 3: normalize so the leading one sits in the top bit
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         s3_in[i]      = s2_ff[i];
         s3_in[i].word = s2_ff[i].word << (PosW'(WordW - 1) - s2_ff[i].pos);
      end
   end

   // stage 4: round to nearest even and pack
   always_comb begin
      logic [10:0] ex;
      logic        rb, st, inc;
      logic [33:0] ts;
      logic [62:0] td;
      for (int i = 0; i < Lanes; i++) begin
         ex = 11'd943 + {4'd0, s3_ff[i].pos};
         if (s3_ff[i].single) begin
            rb  = s3_ff[i].word[87];
            st  = (|s3_ff[i].word[86:0]) || s3_ff[i].inf;
            inc = rb && (st || s3_ff[i].word[88]);
            ts  = {ex, s3_ff[i].word[110:88]} + {33'd0, inc};
            td  = {ts, 29'd0};
         end else begin
            rb  = s3_ff[i].word[58];
            st  = (|s3_ff[i].word[57:0]) || s3_ff[i].inf;
            inc = rb && (st || s3_ff[i].word[59]);
            ts  = '0;
            td  = {ex, s3_ff[i].word[110:59]} + {62'd0, inc};
         end
         if (s3_ff[i].is_float)  out_in[CompW*i +: CompW] = s3_ff[i].fres;
         else if (s3_ff[i].zero) out_in[CompW*i +: CompW] = {s3_ff[i].sign, 63'd0};
         else                    out_in[CompW*i +: CompW] = {s3_ff[i].sign, td};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

endmodule

/* hdl/vau_checker.sv */
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks of the vertex attribute unpacker.
// ----------------------------------------------------------------------------
module vau_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [vau_pkg::OutW-1:0]  rsp_tdata,
   input logic                      csr_ready
);
   import vau_pkg::*;

   // pipeline freezes only while the output beat is held
   a_ready: assert property (@(posedge clock)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stall");

   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat right after reset");

   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr port not ready");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

endmodule

bind vertex_attribute_unpack vau_checker u_vau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
